FILE: hdl/track_lifecycle_table_defines.svh
// Assertion macros shared by the track lifecycle table RTL.
`ifndef TRACK_LIFECYCLE_TABLE_DEFINES_SVH
`define TRACK_LIFECYCLE_TABLE_DEFINES_SVH

`ifndef SYNTH
// Clocked check that is switched off while reset is asserted.
`define TLT_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Clocked check that is also evaluated during reset.
`define TLT_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TLT_ASSERT(name, prop, msg)
`define TLT_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

FILE: hdl/tlt_pkg.sv
// Shared types, constants and helper functions of the track lifecycle table.
package tlt_pkg;

	// Table size default and fixed field widths.
	localparam int NUM_TRACKS_DEF = 64;
	localparam int SLOT_W         = 6;
	localparam int ID_W           = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 8;

	// Input item modes.
	localparam logic MODE_BIRTH  = 1'b0;
	localparam logic MODE_UPDATE = 1'b1;

	// Counter limits and masks.
	localparam logic [15:0] HIT_MAX    = 16'hFFFF;
	localparam logic [7:0]  CNT_MAX    = 8'hFF;
	localparam logic [7:0]  LAST5_MASK = 8'h1F;
	localparam logic [15:0] ID_MAX     = 16'hFFFF;
	localparam logic [15:0] ID_FIRST   = 16'd1;

	// Register reset values.
	localparam logic [2:0] CONFIRM_HITS_RST  = 3'd3;
	localparam logic [3:0] QUALITY_HITS_RST  = 4'd6;
	localparam logic [7:0] CONF_MISS_RST     = 8'd5;
	localparam logic [7:0] TENT_AGE_RST      = 8'd6;
	localparam logic [7:0] TENT_MISS_RST     = 8'd3;

	typedef enum logic [1:0] {
		ST_FREE = 2'd0,
		ST_TENT = 2'd1,
		ST_CONF = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_FULL      = 2'd1,
		ERR_FREE_SLOT = 2'd2
	} err_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CONFIRM_HITS   = 3'd0,
		CFG_QUALITY_HITS   = 3'd1,
		CFG_CONF_MISS_LIM  = 3'd2,
		CFG_TENT_AGE_LIM   = 3'd3,
		CFG_TENT_MISS_LIM  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0] confirm_hits;
		logic [3:0] quality_hits;
		logic [7:0] conf_miss_lim;
		logic [7:0] tent_age_lim;
		logic [7:0] tent_miss_lim;
	} cfg_t;

	// One track record as held in the record memory.
	typedef struct packed {
		logic [7:0]      history;
		logic [15:0]     hits;
		logic [7:0]      misses;
		logic [7:0]      age;
		logic [ID_W-1:0] id;
	} rec_t;

	// Outcome of one epoch update.
	typedef struct packed {
		rec_t    rec;
		status_t status;
		logic    quality;
	} upd_t;

	// Number of set bits in a byte.
	function automatic logic [3:0] popcnt8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int b = 0; b < 8; b++) begin
			n = n + 4'(v[b]);
		end
		return n;
	endfunction

endpackage

FILE: hdl/tlt_rec_mem.sv
// Track record memory: one write port, one registered read port.
module tlt_rec_mem import tlt_pkg::*; #(
	parameter int DEPTH = NUM_TRACKS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  rec_t          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output rec_t          rdata
);

	rec_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/tlt_free_find.sv
// Finds the lowest-numbered free slot in the occupancy vector.
module tlt_free_find import tlt_pkg::*; #(
	parameter int NUM = NUM_TRACKS_DEF,
	localparam int IW = $clog2(NUM)
) (
	input  logic [NUM-1:0] free_vec,
	output logic           found,
	output logic [IW-1:0]  idx
);

	// Priority encoder, lowest index wins.
	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = NUM - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				found = 1'b1;
				idx   = IW'(i);
			end
		end
	end

endmodule

FILE: hdl/tlt_rec_upd.sv
// Epoch update of one track record: counters, history and M-of-N lifecycle decision.
module tlt_rec_upd import tlt_pkg::*; (
	input  rec_t    rec,
	input  status_t status_in,
	input  logic    radar_hit,
	input  cfg_t    cfg,
	output upd_t    upd
);

	logic [7:0] hist_new;
	logic [2:0] last5;
	rec_t       rec_new;
	status_t    st_new;

	// Shift the hit into the history and step the saturating counters.
	always_comb begin
		hist_new = {rec.history[6:0], radar_hit};
		rec_new = rec;
		rec_new.history = hist_new;
		if (radar_hit) begin
			rec_new.hits   = (rec.hits == HIT_MAX) ? rec.hits : rec.hits + 16'd1;
			rec_new.misses = '0;
		end else begin
			rec_new.misses = (rec.misses == CNT_MAX) ? rec.misses : rec.misses + 8'd1;
		end
		rec_new.age = (rec.age == CNT_MAX) ? rec.age : rec.age + 8'd1;
	end

	// Confirmation, early drop of tentative tracks and deletion on misses.
	always_comb begin
		last5  = 3'(popcnt8(hist_new & LAST5_MASK));
		st_new = status_in;
		case (status_in)
			ST_TENT: begin
				if (last5 >= cfg.confirm_hits) begin
					st_new = ST_CONF;
				end else if (rec_new.age >= cfg.tent_age_lim ||
				             rec_new.misses >= cfg.tent_miss_lim) begin
					st_new = ST_FREE;
				end
			end
			default: st_new = status_in;
		endcase
		// A track confirmed in this epoch is still subject to the miss limit.
		if (st_new == ST_CONF && rec_new.misses >= cfg.conf_miss_lim) begin
			st_new = ST_FREE;
		end
	end

	assign upd.rec     = rec_new;
	assign upd.status  = st_new;
	assign upd.quality = (st_new == ST_CONF) && (popcnt8(hist_new) >= cfg.quality_hits);

endmodule

FILE: hdl/track_lifecycle_table.sv
// Top level of the track lifecycle table.
//
// The table holds NUM_TRACKS track records and takes one transaction per clock unless the
// result is stalled: a birth claims the lowest free slot, an update advances one slot by an
// epoch and applies M-of-N confirmation and deletion. Every transaction yields exactly one
// result transaction: the accepting edge loads the input register, and the result register
// is loaded from the input register when empty or taken. A stalled result holds the input
// stage, so the input stays ready only while the input stage can drain. Throughput is one
// transaction per cycle unless the result is stalled, set by the single read-modify-write
// of the record memory, whose read is issued at acceptance and forwarded from a same-slot
// write of the item ahead. Slot status is held in flip-flops and cleared by reset, so no
// clearing pass is needed; the other record fields are written at birth before they can be
// read. Configuration writes are expected only while no transaction is in flight.
`include "track_lifecycle_table_defines.svh"

module track_lifecycle_table import tlt_pkg::*; #(
	parameter int NUM_TRACKS = NUM_TRACKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Input transaction.
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  logic [SLOT_W-1:0]     slot,
	input  logic                  radar_hit,
	// Result transaction.
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SLOT_W-1:0]     slot_out,
	output logic [ID_W-1:0]       track_id,
	output logic [1:0]            status,
	output logic                  quality,
	output logic [1:0]            error
);

	localparam int IDX_W = $clog2(NUM_TRACKS);

	// Handshake and stage control.
	logic accept;
	logic commit;

	// Configuration registers.
	cfg_t cfg_q;

	// Input stage.
	logic              valid_s1;
	logic              mode_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              hit_s1;
	logic              byp_s1;
	rec_t              byp_rec_s1;

	// Result stage.
	logic              valid_s2;
	logic [SLOT_W-1:0] slot_s2;
	logic [ID_W-1:0]   id_s2;
	status_t           status_s2;
	logic              quality_s2;
	err_t              error_s2;

	// Table state.
	status_t         status_q [NUM_TRACKS];
	logic [ID_W-1:0] next_id_q;

	// Datapath.
	logic [NUM_TRACKS-1:0] free_vec;
	logic                  free_found;
	logic [IDX_W-1:0]      free_idx;
	logic                  in_range;
	logic [IDX_W-1:0]      upd_idx;
	status_t               cur_status;
	rec_t                  rd_rec;
	rec_t                  cur_rec;
	upd_t                  upd;
	logic                  birth_ok;

	// Write-back controls and result payload.
	logic             st_we;
	logic [IDX_W-1:0] st_widx;
	status_t          st_wval;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	rec_t             mem_wdata;
	logic             id_adv;
	logic [SLOT_W-1:0] res_slot;
	logic [ID_W-1:0]   res_id;
	status_t           res_status;
	logic              res_quality;
	err_t              res_error;

	// Handshake: the input stage drains into the result register when it is empty or taken.
	assign commit   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || commit;
	assign accept   = in_valid && in_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.confirm_hits  <= CONFIRM_HITS_RST;
			cfg_q.quality_hits  <= QUALITY_HITS_RST;
			cfg_q.conf_miss_lim <= CONF_MISS_RST;
			cfg_q.tent_age_lim  <= TENT_AGE_RST;
			cfg_q.tent_miss_lim <= TENT_MISS_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CONFIRM_HITS:  cfg_q.confirm_hits  <= cfg_data[2:0];
				CFG_QUALITY_HITS:  cfg_q.quality_hits  <= cfg_data[3:0];
				CFG_CONF_MISS_LIM: cfg_q.conf_miss_lim <= cfg_data;
				CFG_TENT_AGE_LIM:  cfg_q.tent_age_lim  <= cfg_data;
				CFG_TENT_MISS_LIM: cfg_q.tent_miss_lim <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byp_s1   <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			byp_s1   <= accept && commit && mem_we && (mem_waddr == IDX_W'(slot));
		end
	end

	// Input stage payload, with the record written by the item ahead kept for forwarding.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1    <= mode;
			slot_s1    <= slot;
			hit_s1     <= radar_hit;
			byp_rec_s1 <= mem_wdata;
		end
	end

	// Record memory, read at acceptance.
	tlt_rec_mem #(
		.DEPTH(NUM_TRACKS)
	) u_mem (
		.clk   (clk),
		.we    (commit && mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (IDX_W'(slot)),
		.rdata (rd_rec)
	);

	// Occupancy vector and first free slot.
	always_comb begin
		for (int i = 0; i < NUM_TRACKS; i++) begin
			free_vec[i] = (status_q[i] == ST_FREE);
		end
	end

	tlt_free_find #(
		.NUM(NUM_TRACKS)
	) u_find (
		.free_vec (free_vec),
		.found    (free_found),
		.idx      (free_idx)
	);

	// Current record and status of the addressed slot; slots past the table read as free.
	assign in_range   = (32'(slot_s1) < NUM_TRACKS);
	assign upd_idx    = IDX_W'(slot_s1);
	assign cur_status = in_range ? status_q[upd_idx] : ST_FREE;
	assign cur_rec    = byp_s1 ? byp_rec_s1 : rd_rec;

	tlt_rec_upd u_upd (
		.rec       (cur_rec),
		.status_in (cur_status),
		.radar_hit (hit_s1),
		.cfg       (cfg_q),
		.upd       (upd)
	);

	assign birth_ok = (mode_s1 == MODE_BIRTH) && free_found;

	// Write-back and result selection for the item in the input stage.
	always_comb begin
		st_we       = 1'b0;
		st_widx     = upd_idx;
		st_wval     = upd.status;
		mem_we      = 1'b0;
		mem_waddr   = upd_idx;
		mem_wdata   = upd.rec;
		id_adv      = 1'b0;
		res_slot    = slot_s1;
		res_id      = '0;
		res_status  = ST_FREE;
		res_quality = 1'b0;
		res_error   = ERR_NONE;
		if (mode_s1 == MODE_BIRTH) begin
			if (free_found) begin
				st_we             = 1'b1;
				st_widx           = free_idx;
				st_wval           = ST_TENT;
				mem_we            = 1'b1;
				mem_waddr         = free_idx;
				mem_wdata.history = 8'd1;
				mem_wdata.hits    = 16'd1;
				mem_wdata.misses  = '0;
				mem_wdata.age     = '0;
				mem_wdata.id      = next_id_q;
				id_adv            = 1'b1;
				res_slot          = SLOT_W'(free_idx);
				res_id            = next_id_q;
				res_status        = ST_TENT;
			end else begin
				res_slot  = '0;
				res_error = ERR_FULL;
			end
		end else if (cur_status == ST_FREE) begin
			res_error = ERR_FREE_SLOT;
		end else begin
			st_we       = 1'b1;
			mem_we      = 1'b1;
			res_id      = cur_rec.id;
			res_status  = upd.status;
			res_quality = upd.quality;
		end
	end

	// Slot status and track id counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TRACKS; i++) begin
				status_q[i] <= ST_FREE;
			end
			next_id_q <= ID_FIRST;
		end else if (commit) begin
			if (st_we) begin
				status_q[st_widx] <= st_wval;
			end
			if (id_adv) begin
				next_id_q <= (next_id_q == ID_MAX) ? ID_FIRST : next_id_q + 16'd1;
			end
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (commit) begin
			slot_s2    <= res_slot;
			id_s2      <= res_id;
			status_s2  <= res_status;
			quality_s2 <= res_quality;
			error_s2   <= res_error;
		end
	end

	assign out_valid = valid_s2;
	assign slot_out  = slot_s2;
	assign track_id  = id_s2;
	assign status    = status_s2;
	assign quality   = quality_s2;
	assign error     = error_s2;

	// A committed birth leaves its slot tentative.
	`TLT_ASSERT(a_birth_tent, commit && birth_ok |=> status_q[$past(free_idx)] == ST_TENT, "born slot not tentative")
	// The id counter steps on every committed birth and never reaches zero.
	`TLT_ASSERT(a_id_step, commit && birth_ok |=> next_id_q != $past(next_id_q) && next_id_q != '0, "track id did not advance")
	// Quality is only reported for confirmed tracks.
	`TLT_ASSERT(a_quality_conf, valid_s2 && quality_s2 |-> status_s2 == ST_CONF, "quality without confirmation")
	// An error result carries no track.
	`TLT_ASSERT(a_err_empty, valid_s2 && error_s2 != ERR_NONE |-> id_s2 == '0 && status_s2 == ST_FREE, "error result carries a track")
	// Forwarding is only armed behind a committed item.
	`TLT_ASSERT_ALWAYS(a_byp_valid, !arst_n || !byp_s1 || valid_s1, "forwarding without an item")

endmodule
